@@ hw/rtl/aes256_pkg.sv @@
// Shared AES-256 types, constants and round functions.
package aes256_pkg;

    localparam int unsigned KeyWords = 4;
    localparam int unsigned RkDepth = 60;
    localparam int unsigned RkAddrW = 6;
    localparam logic [3:0]  PosMask = 4'hf;
    localparam logic [3:0]  LastRound = 4'd14;

    typedef enum logic {
        REQ_CRYPT  = 1'b0,
        REQ_LENGTH = 1'b1
    } t_req;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // State byte k sits at bits [127-8k -: 8].
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox(s[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

@@ hw/rtl/aes256_core.sv @@
// Iterative AES-256 block encryptor with the key schedule held in a word memory.
module aes256_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_key,
    input  logic [127:0] i_block,
    output logic         o_done,
    output logic [127:0] o_block
);
    import aes256_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPAND = 4'b0010,
        S_ROUND  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [31:0]  r_rk [RkDepth];
    logic [31:0]  r_rd;
    logic [RkAddrW-1:0] r_idx, n_idx;
    logic [RkAddrW-1:0] rd_addr;
    logic [31:0]  r_win [8];        // last eight schedule words
    logic [127:0] r_st, r_blk;
    logic [3:0]   r_round;
    logic [1:0]   r_col;
    logic [127:0] r_rkey;
    logic [2:0]   r_lag;            // round key read pipeline phase
    logic [31:0]  sched_t, sched_w;
    logic [127:0] round_in;

    // Next schedule word from the sliding window.
    always_comb begin
        sched_t = r_win[7];
        if (r_idx[2:0] == 3'd0) begin
            sched_t = sub_word({r_win[7][23:0], r_win[7][31:24]})
                      ^ ({24'd0, 8'h01} << (r_idx[5:3] - 3'd1)) << 24;
        end else if (r_idx[2:0] == 3'd4) begin
            sched_t = sub_word(r_win[7]);
        end
        sched_w = r_win[0] ^ sched_t;
    end

    assign rd_addr = RkAddrW'({r_round, r_col});

    always_ff @(posedge i_clk) begin
        r_rd <= r_rk[rd_addr];
        if (r_state == S_EXPAND) begin
            r_rk[r_idx] <= (r_idx < RkAddrW'(8)) ? r_win[r_idx[2:0]] : sched_w;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE:   if (i_start) begin n_state = S_EXPAND; n_idx = '0; end
            S_EXPAND: begin
                n_idx = r_idx + RkAddrW'(1);
                if (r_idx == RkAddrW'(RkDepth - 1)) n_state = S_ROUND;
            end
            S_ROUND:  if (r_round == LastRound && r_col == 2'd3 && r_lag == 3'd2)
                          n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Round r: AddRoundKey first at r = 0, else sub/shift, mix (not last), add.
    always_comb begin
        if (r_round == 4'd0) round_in = r_blk;
        else if (r_round == LastRound) round_in = sub_shift(r_st);
        else round_in = mix_columns(sub_shift(r_st));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_round <= '0;
            r_col   <= '0;
            r_lag   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            case (r_state)
                S_IDLE: begin
                    r_round <= '0;
                    r_col   <= '0;
                    r_lag   <= '0;
                end
                S_EXPAND: ;
                S_ROUND: begin
                    // Read four words of a round, one per cycle, then apply.
                    if (r_lag == 3'd2) begin
                        r_lag   <= '0;
                        r_col   <= '0;
                        r_round <= r_round + 4'd1;
                    end else if (r_col == 2'd3) begin
                        r_lag <= r_lag + 3'd1;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // Payload path: window, key gather and state update.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            for (int k = 0; k < 8; k++) r_win[k] <= i_key[255 - 32*k -: 32];
            r_blk <= i_block;
        end else if (r_state == S_EXPAND && r_idx >= RkAddrW'(8)) begin
            for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
            r_win[7] <= sched_w;
        end
        if (r_state == S_ROUND) begin
            // Read data comes from a registered memory read, in the cycle after its address.
            if (r_col != 2'd0 || r_lag == 3'd1) begin
                r_rkey <= {r_rkey[95:0], r_rd};
            end
            if (r_lag == 3'd2) r_st <= round_in ^ r_rkey;
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_block = r_st;
endmodule

@@ hw/rtl/aes256_ctr_stream_cipher.sv @@
// Top level of the AES-256 counter-mode byte stream cipher.
//
// Input channel: one beat carries a request type, a start flag, a 128-bit
// counter, a data byte and an encrypted length word. Output channel: one beat
// per input beat with the crypted byte, the decrypted length and the counter.
// The key is four 64-bit words on a plain write port; the user must write it only while idle (unenforced).
//
// A crypt beat at byte position zero, and every length beat, runs one AES
// block: a start step, key expansion of all 60 words into the round key memory
// (one word per cycle), 15 rounds with four round key reads each, then a done
// step, after which the result is offered. Other crypt beats skip the AES block
// and offer their result from the finish step.
//
// Reset clears counter, keystream, byte position and the handshake state.
// The round key memory needs no clearing: each block rewrites it first.
// The input is held off while a beat is in work. A stalled result waits in
// the output register; the next input beat is still taken and computed, and
// its result holds in the finish step until the output register frees up.
module aes256_ctr_stream_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic        i_start_message,
    input  logic [63:0] i_counter_high,
    input  logic [63:0] i_counter_low,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_enc_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_length_value,
    output logic [63:0] o_next_counter_high,
    output logic [63:0] o_next_counter_low
);
    import aes256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_AES  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    logic [63:0]  r_key [KeyWords];
    logic [127:0] r_ctr, r_ks;
    logic [3:0]   r_pos;
    logic         r_req;
    logic [7:0]   r_data;
    logic [31:0]  r_len;
    logic         r_ovalid;
    logic         aes_start, aes_done;
    logic [127:0] aes_blk, aes_out;
    logic [255:0] key_flat;
    logic         in_acc, out_free;
    logic [127:0] ctr_eff;
    logic [3:0]   pos_eff;

    for (genvar g = 0; g < KeyWords; g++) begin : g_key
        assign key_flat[255 - 64*g -: 64] = r_key[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KeyWords; k++) r_key[k] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;

    assign ctr_eff = i_start_message ? {i_counter_high, i_counter_low} : r_ctr;
    assign pos_eff = (i_start_message ? 4'd0 : r_pos) & PosMask;
    assign aes_blk = (t_req'(i_req_type) == REQ_LENGTH) ?
                     {i_counter_high, i_counter_low} : ctr_eff;
    assign aes_start = in_acc && ((t_req'(i_req_type) == REQ_LENGTH) || pos_eff == 4'd0);

    aes256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (aes_start),
        .i_key   (key_flat),
        .i_block (aes_blk),
        .o_done  (aes_done),
        .o_block (aes_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctr    <= '0;
            r_ks     <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_req  <= i_req_type;
                    r_data <= i_data_byte;
                    r_len  <= i_enc_length;
                    if (t_req'(i_req_type) == REQ_CRYPT) begin
                        r_ctr <= ctr_eff;
                        r_pos <= pos_eff;
                    end
                    r_state <= aes_start ? S_AES : S_FIN;
                end
                S_AES: if (aes_done) begin
                    if (t_req'(r_req) == REQ_CRYPT) begin
                        r_ks  <= aes_out;
                        r_ctr <= r_ctr + 128'd1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: if (out_free) begin
                    // Produce the result beat once the output register is free.
                    // The core holds its block output while idle.
                    if (t_req'(r_req) == REQ_CRYPT) begin
                        o_out_byte     <= r_data ^ r_ks[127 - 8*r_pos -: 8];
                        o_length_value <= 32'd0;
                        r_pos          <= (r_pos + 4'd1) & PosMask;
                    end else begin
                        o_out_byte     <= 8'd0;
                        o_length_value <= r_len ^ aes_out[127:96];
                    end
                    o_next_counter_high <= r_ctr[127:64];
                    o_next_counter_low  <= r_ctr[63:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_FIN && out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
endmodule

@@ verif/aes256_ctr_stream_cipher_tb.sv @@
// Self-checking testbench for the AES-256 counter-mode byte stream cipher.
module aes256_ctr_stream_cipher_tb;
    import aes256_pkg::*;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] length_value;
        logic [63:0] ctr_high;
        logic [63:0] ctr_low;
    } t_cipher_beat;

    // Cipher prediction and result queue in one small class.
    class cipher_scoreboard;
        logic [63:0]  key_reg [4];
        logic [127:0] counter;
        logic [127:0] keystream;
        logic [3:0]   position;
        t_cipher_beat pending_q [$];
        int           fail_count;

        function new();
            for (int k = 0; k < 4; k++) key_reg[k] = '0;
            counter = '0;
            keystream = '0;
            position = '0;
            fail_count = 0;
        endfunction

        function automatic logic [7:0] sb(input logic [7:0] a);
            logic [7:0] t [256];
            t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
            return t[a];
        endfunction

        function automatic logic [31:0] sub4(input logic [31:0] w);
            return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
        endfunction

        function automatic logic [7:0] xt(input logic [7:0] b);
            return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        endfunction

        // Encrypt one block under the current key; byte k at bits [127-8k -: 8].
        function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
            logic [31:0]  rk [60];
            logic [31:0]  tw;
            logic [7:0]   rc;
            logic [127:0] s, t;
            logic [7:0]   a0, a1, a2, a3, al;
            rc = 8'h01;
            for (int i = 0; i < 8; i++) rk[i] = key_reg[i/2][63 - 32*(i%2) -: 32];
            for (int i = 8; i < 60; i++) begin
                tw = rk[i-1];
                if (i % 8 == 0) begin
                    tw = sub4({tw[23:0], tw[31:24]}) ^ {rc, 24'h0};
                    rc = xt(rc);
                end else if (i % 8 == 4) begin
                    tw = sub4(tw);
                end
                rk[i] = rk[i-8] ^ tw;
            end
            s = blk ^ {rk[0], rk[1], rk[2], rk[3]};
            for (int r = 1; r <= 14; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[127 - 8*(w + 4*c) -: 8] = sb(s[127 - 8*(w + 4*((c + w) % 4)) -: 8]);
                s = t;
                if (r < 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[127 - 32*c -: 8];
                        a1 = s[119 - 32*c -: 8];
                        a2 = s[111 - 32*c -: 8];
                        a3 = s[103 - 32*c -: 8];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        t[127 - 32*c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
                        t[119 - 32*c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
                        t[111 - 32*c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
                        t[103 - 32*c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
                    end
                    s = t;
                end
                s = s ^ {rk[4*r], rk[4*r+1], rk[4*r+2], rk[4*r+3]};
            end
            return s;
        endfunction

        function void note_beat(input logic rt, input logic st, input logic [127:0] ctr,
                                input logic [7:0] db, input logic [31:0] el);
            t_cipher_beat e;
            logic [127:0] ks;
            e = '0;
            if (rt == REQ_CRYPT) begin
                if (st) begin
                    counter = ctr;
                    position = '0;
                end
                if (position == 0) begin
                    keystream = encrypt_block(counter);
                    counter = counter + 128'd1;
                end
                e.out_byte = db ^ keystream[127 - 8*position -: 8];
                position = position + 4'd1;
            end else begin
                ks = encrypt_block(ctr);
                e.length_value = el ^ ks[127:96];
            end
            e.ctr_high = counter[127:64];
            e.ctr_low = counter[63:0];
            pending_q.push_back(e);
        endfunction

        function void check_beat(input t_cipher_beat got);
            t_cipher_beat e;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat");
                fail_count++;
                return;
            end
            e = pending_q.pop_front();
            if (got.out_byte !== e.out_byte) begin
                $error("out_byte exp %h got %h", e.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.length_value !== e.length_value) begin
                $error("length_value exp %h got %h", e.length_value, got.length_value);
                fail_count++;
            end
            if (got.ctr_high !== e.ctr_high) begin
                $error("next_counter_high exp %h got %h", e.ctr_high, got.ctr_high);
                fail_count++;
            end
            if (got.ctr_low !== e.ctr_low) begin
                $error("next_counter_low exp %h got %h", e.ctr_low, got.ctr_low);
                fail_count++;
            end
        endfunction
    endclass

    localparam int WatchdogLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic        i_start_message = 1'b0;
    logic [63:0] i_counter_high = '0;
    logic [63:0] i_counter_low = '0;
    logic [7:0]  i_data_byte = '0;
    logic [31:0] i_enc_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [31:0] o_length_value;
    logic [63:0] o_next_counter_high;
    logic [63:0] o_next_counter_low;

    cipher_scoreboard sbd = new();
    int  idle_cycles = 0;
    bit  stall_enable = 1'b1;

    aes256_ctr_stream_cipher dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pick a gap: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Check result beats and predict on accepted input beats; count idle cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sbd.check_beat({o_out_byte, o_length_value, o_next_counter_high,
                                o_next_counter_low});
            if (i_valid && !o_stall)
                sbd.note_beat(i_req_type, i_start_message, {i_counter_high, i_counter_low},
                              i_data_byte, i_enc_length);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Randomly stall the result side; hold stall low while stall_enable is clear.
    always @(posedge i_clk) begin
        if (stall_enable && $urandom_range(0, 99) < 30)
            i_stall <= ($urandom_range(0, 9) < 8) ? 1'b1 : ($urandom_range(0, 1) == 1);
        else
            i_stall <= 1'b0;
    end

    // Write all four key words, one per cycle, then drop the write enable.
    task automatic write_keys(input logic [63:0] kv [4]);
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 2'(k);
            i_cfg_data <= kv[k];
            @(posedge i_clk);
            sbd.key_reg[k] = kv[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    // After a random gap, present one beat and hold it until it is taken.
    task automatic send_beat(input logic rt, input logic st, input logic [63:0] ch,
                             input logic [63:0] cl, input logic [7:0] db,
                             input logic [31:0] el);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rt;
        i_start_message <= st;
        i_counter_high <= ch;
        i_counter_low <= cl;
        i_data_byte <= db;
        i_enc_length <= el;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sbd.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // A message of random length under a fresh counter, sometimes near the wrap.
    task automatic send_message();
        logic [63:0] ch, cl;
        int n;
        ch = rand64();
        cl = rand64();
        if ($urandom_range(0, 9) == 0) begin
            ch = '1;
            cl = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 2));
        end
        n = $urandom_range(1, 50);
        send_beat(REQ_CRYPT, 1'b1, ch, cl, 8'($urandom()), $urandom());
        for (int k = 1; k < n; k++)
            send_beat(REQ_CRYPT, 1'b0, rand64(), rand64(), 8'($urandom()), $urandom());
    endtask

    initial begin
        logic [63:0] key_set [4];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero key, crypt straight after reset with no start.
        send_beat(REQ_CRYPT, 1'b0, '1, '1, 8'h00, '0);
        send_beat(REQ_CRYPT, 1'b0, '0, '0, 8'hff, '1);
        send_beat(REQ_LENGTH, 1'b1, '1, '1, 8'hff, '1);
        send_beat(REQ_LENGTH, 1'b0, '0, '0, 8'h00, '0);
        // Counter wrap from all ones.
        send_beat(REQ_CRYPT, 1'b1, '1, '1, 8'h5a, '0);
        for (int k = 0; k < 16; k++)
            send_beat(REQ_CRYPT, 1'b0, '0, '0, 8'ha5, '0);
        drain();

        // Several key settings: all ones, FIPS-197 style key, then random ones.
        for (int phase = 0; phase < 6; phase++) begin
            for (int k = 0; k < 4; k++) begin
                case (phase)
                    0: key_set[k] = '1;
                    1: key_set[k] = {8'(8*k), 8'(8*k+1), 8'(8*k+2), 8'(8*k+3),
                                     8'(8*k+4), 8'(8*k+5), 8'(8*k+6), 8'(8*k+7)};
                    default: key_set[k] = rand64();
                endcase
            end
            write_keys(key_set);
            stall_enable = (phase != 2);
            for (int m = 0; m < 6; m++) begin
                send_message();
                if ($urandom_range(0, 2) == 0)
                    send_beat(REQ_LENGTH, 1'($urandom_range(0, 1)), rand64(), rand64(),
                              8'($urandom()), $urandom());
                if ($urandom_range(0, 4) == 0)
                    send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand64(),
                              rand64(), 8'($urandom()), $urandom());
            end
            drain();
        end
        for (int k = 0; k < 4; k++) key_set[k] = '0;
        write_keys(key_set);
        send_message();
        drain();

        if (sbd.fail_count == 0 && sbd.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
